// ----- src/rit_pkg.sv -----
// Package for the radix integer-to-text block: widths, character codes,
// register indexes, the command and status structs, and the symbol lookup.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rit_pkg;

  // Fixed widths of the payload and of the configuration port.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned REG_IDX_W  = 2;

  // Alphabet storage: sixteen byte symbols in two words.
  localparam int unsigned SYM_COUNT  = 16;
  localparam int unsigned SYM_IDX_W  = 4;

  // Quotient bits produced per clock by the digit divider.
  localparam int unsigned STEP_BITS  = 8;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_RADIX  = 16;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

  // Register indexes, taken from paddr bits 4:3.
  localparam logic [REG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd2;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [COUNT_W-1:0] digit_count;
    logic [WORD_W-1:0]  alphabet_low;
    logic [WORD_W-1:0]  alphabet_high;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic divide;
    logic pop;
    logic show_sign;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;
    logic conv_done;
    logic negative;
    logic last_digit;
  } ctrl_status_t;

  // Byte of symbol idx from the two alphabet words.
  function automatic logic [CHAR_W-1:0] sym_at(input logic [WORD_W-1:0] lo,
                                               input logic [WORD_W-1:0] hi,
                                               input logic [SYM_IDX_W-1:0] idx);
    logic [WORD_W-1:0] word;
    word = idx[SYM_IDX_W-1] ? hi : lo;
    return word[{idx[SYM_IDX_W-2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

// ----- src/rit_in_if.sv -----
// Input channel of the radix integer-to-text block: one signed value a beat.
// Uses the width constants of rit_pkg.
`timescale 1ns / 1ps

interface rit_in_if
  import rit_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- src/rit_out_if.sv -----
// Output channel of the radix integer-to-text block: one character a beat.
// Uses the width constants of rit_pkg.
`timescale 1ns / 1ps

interface rit_out_if
  import rit_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/rit_cfg.sv -----
// APB-style register file: digit count and the two alphabet words.
// Depends on rit_pkg for widths, register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module rit_cfg
  import rit_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [COUNT_W-1:0]   digit_count_q;
  logic [WORD_W-1:0]    alphabet_low_q;
  logic [WORD_W-1:0]    alphabet_high_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Registers sit eight bytes apart.
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes in the access phase; an unmapped index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q   <= DIGIT_COUNT_RESET;
      alphabet_low_q  <= '0;
      alphabet_high_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIGIT_COUNT:   digit_count_q   <= pwdata[COUNT_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low_q  <= pwdata[WORD_W-1:0];
        REG_ALPHABET_HIGH: alphabet_high_q <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back decoder.
  always_comb begin
    unique case (reg_idx)
      REG_DIGIT_COUNT:   prdata = CFG_DATA_W'(digit_count_q);
      REG_ALPHABET_LOW:  prdata = alphabet_low_q;
      REG_ALPHABET_HIGH: prdata = alphabet_high_q;
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.digit_count   = digit_count_q;
  assign cfg_o.alphabet_low  = alphabet_low_q;
  assign cfg_o.alphabet_high = alphabet_high_q;

endmodule

// ----- src/rit_ctrl.sv -----
// Controller of the radix integer-to-text block: sequences load, alphabet
// check, digit division and character output. Depends on rit_pkg structs.
`timescale 1ns / 1ps

module rit_ctrl
  import rit_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_SIGN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // An invalid alphabet drops the item without output.
        state_d = status_i.alpha_ok ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        cmd_o.divide = 1'b1;
        if (status_i.conv_done) begin
          state_d = status_i.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid_o     = 1'b1;
        cmd_o.show_sign = 1'b1;
        if (out_ready_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          if (status_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/rit_dp.sv -----
// Datapath of the radix integer-to-text block: magnitude, digit divider,
// digit stack, alphabet check and character select. Depends on rit_pkg.
`timescale 1ns / 1ps

module rit_dp
  import rit_pkg::*;
#(
  parameter int unsigned MAX_RADIX  = DEF_MAX_RADIX,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  ctrl_cmd_t                 cmd_i,
  output ctrl_status_t              status_o,
  output logic [CHAR_W-1:0]         character_o,
  output logic                      last_o
);

  localparam int unsigned DIGIT_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned DEPTH    = VALUE_BITS;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned HELD_W   = $clog2(DEPTH + 1);
  localparam int unsigned STEPS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W    = STEPS * STEP_BITS;
  localparam int unsigned STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CMP_W    = COUNT_W + 1;

  logic [PAD_W-1:0]     work_q, work_d;
  logic [DIGIT_W-1:0]   rem_q;
  logic [STEP_W-1:0]    step_q;
  logic [HELD_W-1:0]    held_q;
  logic                 neg_q;
  logic [DIGIT_W-1:0]   stack_q [DEPTH];

  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] mag;
  logic [CMP_W-1:0]      rem_v;
  logic [CMP_W-1:0]      trial;
  logic [STEP_BITS-1:0]  qbits;
  logic                  last_step;
  logic [HELD_W-1:0]     rd_ptr;
  logic [DIGIT_W-1:0]    rd_digit;
  logic                  alpha_ok;
  logic [CHAR_W-1:0]     sym_i;

  // Sign and magnitude of the low VALUE_BITS bits; the most negative value
  // wraps to its own magnitude.
  assign v_in = value_i[VALUE_BITS-1:0];
  assign mag  = v_in[VALUE_BITS-1] ? (~v_in + 1'b1) : v_in;

  // One divider step: STEP_BITS bits of restoring long division by the radix.
  always_comb begin
    rem_v = CMP_W'(rem_q);
    qbits = '0;
    trial = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial = {rem_v[CMP_W-2:0], work_q[PAD_W-1-k]};
      if (trial >= CMP_W'(cfg_i.digit_count)) begin
        qbits[STEP_BITS-1-k] = 1'b1;
        rem_v = trial - CMP_W'(cfg_i.digit_count);
      end else begin
        rem_v = trial;
      end
    end
    work_d = (work_q << STEP_BITS) | PAD_W'(qbits);
  end

  assign last_step = (step_q == STEP_W'(STEPS - 1));

  // Working registers and digit count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q  <= '0;
      step_q <= '0;
      held_q <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      work_q <= PAD_W'(mag);
      rem_q  <= '0;
      step_q <= '0;
      held_q <= '0;
      neg_q  <= v_in[VALUE_BITS-1];
    end else if (cmd_i.divide) begin
      work_q <= work_d;
      if (last_step) begin
        rem_q  <= '0;
        step_q <= '0;
        held_q <= held_q + 1'b1;
      end else begin
        rem_q  <= rem_v[DIGIT_W-1:0];
        step_q <= step_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      held_q <= held_q - 1'b1;
    end
  end

  // Digit stack, least significant digit first; no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.divide && last_step) begin
      stack_q[held_q[IDX_W-1:0]] <= rem_v[DIGIT_W-1:0];
    end
  end

  assign rd_ptr   = held_q - 1'b1;
  assign rd_digit = stack_q[rd_ptr[IDX_W-1:0]];

  // Alphabet check: radix range, forbidden bytes and repeats among the
  // symbols in use.
  always_comb begin
    alpha_ok = (cfg_i.digit_count >= COUNT_W'(2)) &&
               (cfg_i.digit_count <= COUNT_W'(MAX_RADIX));
    sym_i    = '0;
    for (int i = 0; i < MAX_RADIX; i++) begin
      sym_i = sym_at(cfg_i.alphabet_low, cfg_i.alphabet_high, SYM_IDX_W'(i));
      if (COUNT_W'(i) < cfg_i.digit_count) begin
        if (sym_i == NUL_CHAR || sym_i == MINUS_CHAR || sym_i == PLUS_CHAR) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if ((COUNT_W'(j) < cfg_i.digit_count) &&
              (sym_at(cfg_i.alphabet_low, cfg_i.alphabet_high, SYM_IDX_W'(j)) == sym_i)) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Status back to the controller.
  assign status_o.alpha_ok   = alpha_ok;
  assign status_o.conv_done  = last_step && (work_d == '0);
  assign status_o.negative   = neg_q;
  assign status_o.last_digit = (held_q == HELD_W'(1));

  // Character select: minus sign, else the symbol of the top digit.
  assign character_o = cmd_i.show_sign ? MINUS_CHAR :
                       sym_at(cfg_i.alphabet_low, cfg_i.alphabet_high,
                              SYM_IDX_W'(rd_digit));
  assign last_o      = !cmd_i.show_sign && status_o.last_digit;

endmodule

// ----- src/radix_integer_to_text_core.sv -----
// Top level of the radix integer-to-text block: register file, controller
// and datapath. Depends on rit_pkg, rit_in_if, rit_out_if and the submodules.
`timescale 1ns / 1ps

// The block takes one signed value a beat and returns its text, one character
// a beat, most significant digit first, with last set on the final character;
// a negative value starts with a minus sign. The radix is digit_count and the
// symbols come from the alphabet registers; with an invalid alphabet the value
// is consumed and gives no output. Only one value is in work at a time: after
// the input beat the alphabet is checked, then the divider finds each digit,
// retiring eight quotient bits a clock, and then each character is sent when
// the sink is ready.
module radix_integer_to_text_core
  import rit_pkg::*;
#(
  parameter int unsigned MAX_RADIX  = DEF_MAX_RADIX,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rit_in_if.sink                in_i,
  rit_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t         cfg;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Configuration registers.
  rit_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  rit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Conversion datapath.
  rit_dp #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

endmodule
